// ===== rtl/c8_pkg.sv =====
// ----------------------------------------------------------------------------
// c8_pkg
// Shared types, constants and the font table of the interpreter core.
// ----------------------------------------------------------------------------
`default_nettype none

package c8_pkg;

    localparam int STACK_DEPTH  = 16;
    localparam int MEMORY_BYTES = 4096;
    localparam int SP_W         = $clog2(STACK_DEPTH + 1);
    localparam int SP_IDX_W     = $clog2(STACK_DEPTH);
    localparam int MEM_AW       = $clog2(MEMORY_BYTES);
    localparam int IN_W         = 40;
    localparam int OUT_W        = 104;
    localparam int CFG_IDX_W    = 1;
    localparam int CFG_W        = 16;
    localparam int STEP_W       = 5;

    localparam logic [11:0] START_DEFAULT = 12'h200;
    localparam logic [15:0] SEED_DEFAULT  = 16'hACE1;
    localparam int          FONT_BYTES    = 80;

    // request kinds
    localparam logic [1:0] REQ_EXEC  = 2'd0;
    localparam logic [1:0] REQ_WRITE = 2'd1;
    localparam logic [1:0] REQ_TICK  = 2'd2;
    localparam logic [1:0] REQ_ROW   = 2'd3;

    // result status codes
    localparam logic [2:0] STAT_OK        = 3'd0;
    localparam logic [2:0] STAT_OVERFLOW  = 3'd1;
    localparam logic [2:0] STAT_UNDERFLOW = 3'd2;
    localparam logic [2:0] STAT_KEY_WAIT  = 3'd3;
    localparam logic [2:0] STAT_UNKNOWN   = 3'd4;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_START = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SEED  = 1'd1;

    // micro-operations issued by the controller
    typedef enum logic [3:0] {
        UOP_CLEAR    = 4'd0,
        UOP_IDLE     = 4'd1,
        UOP_DISPATCH = 4'd2,
        UOP_FETCH_HI = 4'd3,
        UOP_FETCH_LO = 4'd4,
        UOP_READ_X   = 4'd5,
        UOP_READ_Y   = 4'd6,
        UOP_EXEC     = 4'd7,
        UOP_DRAW_RD  = 4'd8,
        UOP_DRAW_WR  = 4'd9,
        UOP_BCD      = 4'd10,
        UOP_STORE    = 4'd11,
        UOP_LOAD_RD  = 4'd12,
        UOP_LOAD_WR  = 4'd13,
        UOP_RESP     = 4'd14
    } uop_t;

    // multi-cycle instruction classes
    typedef enum logic [2:0] {
        CLS_NONE  = 3'd0,
        CLS_DRAW  = 3'd1,
        CLS_BCD   = 3'd2,
        CLS_STORE = 3'd3,
        CLS_LOAD  = 3'd4
    } cls_t;

    typedef struct packed {
        uop_t uop;
        logic in_xfer;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic [1:0] req;
        cls_t       cls;
        logic       loop_done;
        logic       clear_last;
    } stat_t;

    function automatic logic [7:0] font_byte(input logic [6:0] a);
        logic [7:0] b;
        case (a)
            7'd0, 7'd4, 7'd10, 7'd12, 7'd14, 7'd15, 7'd17, 7'd19, 7'd22,
            7'd25, 7'd27, 7'd29, 7'd30, 7'd32, 7'd34, 7'd35, 7'd40, 7'd42,
            7'd44, 7'd45, 7'd47, 7'd49, 7'd50, 7'd52, 7'd60, 7'd64, 7'd70,
            7'd72, 7'd74, 7'd75, 7'd77: b = 8'hF0;
            7'd1, 7'd2, 7'd3, 7'd20, 7'd21, 7'd33, 7'd41, 7'd43, 7'd46,
            7'd51, 7'd53, 7'd54, 7'd56, 7'd58, 7'd66, 7'd67, 7'd68: b = 8'h90;
            7'd5, 7'd7, 7'd8, 7'd37: b = 8'h20;
            7'd6: b = 8'h60;
            7'd9: b = 8'h70;
            7'd11, 7'd16, 7'd18, 7'd23, 7'd24, 7'd28, 7'd36, 7'd48: b = 8'h10;
            7'd13, 7'd26, 7'd31, 7'd61, 7'd62, 7'd63, 7'd71, 7'd73, 7'd76,
            7'd78, 7'd79: b = 8'h80;
            7'd38, 7'd39: b = 8'h40;
            7'd55, 7'd57, 7'd59, 7'd65, 7'd69: b = 8'hE0;
            default: b = 8'h00;
        endcase
        return b;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/c8_ram.sv =====
// ----------------------------------------------------------------------------
// c8_ram
// Generic single-port RAM with registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module c8_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    input  wire logic [WIDTH-1:0]         wdata,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write, or registered read
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

`default_nettype wire

// ===== rtl/c8_ctrl.sv =====
// ----------------------------------------------------------------------------
// c8_ctrl
// Sequencer of the core: one micro-operation per cycle, handshakes.
// ----------------------------------------------------------------------------
`default_nettype none

module c8_ctrl (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          s_tvalid,
    output logic               s_tready,
    output logic               m_tvalid,
    input  wire logic          m_tready,
    input  wire c8_pkg::stat_t stat,
    output c8_pkg::cmd_t       cmd
);
    import c8_pkg::*;

    typedef enum logic [14:0] {
        ST_CLEAR    = 15'h0001,
        ST_IDLE     = 15'h0002,
        ST_DISPATCH = 15'h0004,
        ST_FETCH_HI = 15'h0008,
        ST_FETCH_LO = 15'h0010,
        ST_READ_X   = 15'h0020,
        ST_READ_Y   = 15'h0040,
        ST_EXEC     = 15'h0080,
        ST_DRAW_RD  = 15'h0100,
        ST_DRAW_WR  = 15'h0200,
        ST_BCD      = 15'h0400,
        ST_STORE    = 15'h0800,
        ST_LOAD_RD  = 15'h1000,
        ST_LOAD_WR  = 15'h2000,
        ST_RESP     = 15'h4000
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   slot_free;
    uop_t   uop;

    assign slot_free = !out_valid_reg || m_tready;
    assign s_tready  = (state_reg == ST_IDLE) && slot_free;
    assign m_tvalid  = out_valid_reg;

    // next state and micro-operation
    always_comb begin
        state_next = state_reg;
        uop        = UOP_IDLE;
        case (state_reg)
            ST_CLEAR: begin
                uop = UOP_CLEAR;
                if (stat.clear_last) state_next = ST_IDLE;
            end
            ST_IDLE: begin
                uop = UOP_IDLE;
                if (s_tvalid && s_tready) state_next = ST_DISPATCH;
            end
            ST_DISPATCH: begin
                uop        = UOP_DISPATCH;
                state_next = (stat.req == REQ_EXEC) ? ST_FETCH_HI : ST_RESP;
            end
            ST_FETCH_HI: begin
                uop        = UOP_FETCH_HI;
                state_next = ST_FETCH_LO;
            end
            ST_FETCH_LO: begin
                uop        = UOP_FETCH_LO;
                state_next = ST_READ_X;
            end
            ST_READ_X: begin
                uop        = UOP_READ_X;
                state_next = ST_READ_Y;
            end
            ST_READ_Y: begin
                uop        = UOP_READ_Y;
                state_next = ST_EXEC;
            end
            ST_EXEC: begin
                uop = UOP_EXEC;
                case (stat.cls)
                    CLS_DRAW:  state_next = ST_DRAW_RD;
                    CLS_BCD:   state_next = ST_BCD;
                    CLS_STORE: state_next = ST_STORE;
                    CLS_LOAD:  state_next = ST_LOAD_RD;
                    default:   state_next = ST_RESP;
                endcase
            end
            ST_DRAW_RD: begin
                uop        = UOP_DRAW_RD;
                state_next = stat.loop_done ? ST_RESP : ST_DRAW_WR;
            end
            ST_DRAW_WR: begin
                uop        = UOP_DRAW_WR;
                state_next = ST_DRAW_RD;
            end
            ST_BCD: begin
                uop = UOP_BCD;
                if (stat.loop_done) state_next = ST_RESP;
            end
            ST_STORE: begin
                uop = UOP_STORE;
                if (stat.loop_done) state_next = ST_RESP;
            end
            ST_LOAD_RD: begin
                uop        = UOP_LOAD_RD;
                state_next = stat.loop_done ? ST_RESP : ST_LOAD_WR;
            end
            ST_LOAD_WR: begin
                uop        = UOP_LOAD_WR;
                state_next = ST_LOAD_RD;
            end
            ST_RESP: begin
                uop = UOP_RESP;
                if (slot_free) state_next = ST_IDLE;
            end
            default: begin
                uop        = UOP_IDLE;
                state_next = ST_IDLE;
            end
        endcase
    end

    // output slot occupancy
    always_comb begin
        out_valid_next = out_valid_reg;
        if (m_tready) out_valid_next = 1'b0;
        if (state_reg == ST_RESP && slot_free) out_valid_next = 1'b1;
    end

    assign cmd.uop      = uop;
    assign cmd.in_xfer  = s_tvalid && s_tready;
    assign cmd.out_load = (state_reg == ST_RESP) && slot_free;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_CLEAR;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/c8_datapath.sv =====
// ----------------------------------------------------------------------------
// c8_datapath
// Registers, memory, frame buffer, stack, timers and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module c8_datapath (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire c8_pkg::cmd_t                    cmd,
    output c8_pkg::stat_t                        stat,
    input  wire logic [1:0]                      s_tuser,
    input  wire logic [c8_pkg::IN_W-1:0]         s_tdata,
    input  wire logic                            cfg_wr_en,
    input  wire logic [c8_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [c8_pkg::CFG_W-1:0]        cfg_wdata,
    output logic      [c8_pkg::OUT_W-1:0]        m_tdata
);
    import c8_pkg::*;

    // architectural state
    logic [7:0]  var_reg [16];
    logic [15:0] index_reg;
    logic [11:0] pc_reg;
    logic [11:0] stack_reg [STACK_DEPTH];
    logic [SP_W-1:0] sp_reg;
    logic [63:0] fb_reg [32];
    logic [7:0]  delay_reg;
    logic [7:0]  sound_reg;
    logic        key_wait_reg;
    logic [15:0] lfsr_reg;

    // request and work registers
    logic [1:0]  req_reg;
    logic [11:0] addr_reg;
    logic [7:0]  wdata_reg;
    logic [15:0] keys_reg;
    logic [15:0] op_reg;
    logic [7:0]  vx_reg;
    logic [7:0]  vy_reg;
    logic [STEP_W-1:0] step_reg;
    logic [11:0] clr_reg;
    logic        hit_reg;
    logic [2:0]  status_reg;
    logic        drew_reg;
    logic [OUT_W-1:0] out_reg;

    // memory port
    logic              ram_we;
    logic [MEM_AW-1:0] ram_addr;
    logic [7:0]        ram_wdata;
    logic [7:0]        ram_rdata;

    c8_ram #(.WIDTH(8), .DEPTH(MEMORY_BYTES)) u_mem (
        .aclk  (aclk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    // opcode fields
    logic [3:0]  op_x, op_y, op_n, op_hi;
    logic [7:0]  op_kk;
    logic [11:0] op_nnn;
    assign op_hi  = op_reg[15:12];
    assign op_x   = op_reg[11:8];
    assign op_y   = op_reg[7:4];
    assign op_n   = op_reg[3:0];
    assign op_kk  = op_reg[7:0];
    assign op_nnn = op_reg[11:0];

    // loop addressing
    logic [16:0] idx_sum;
    logic [5:0]  row_sum;
    logic [4:0]  row_idx;
    logic [63:0] sprite_row;
    assign idx_sum    = {1'b0, index_reg} + 17'(step_reg);
    assign row_sum    = {1'b0, vy_reg[4:0]} + 6'(step_reg);
    assign row_idx    = row_sum[4:0];
    assign sprite_row = {ram_rdata, 56'd0} >> vx_reg[5:0];

    // bcd digits
    logic [1:0] bcd_h;
    logic [6:0] bcd_r;
    logic [14:0] bcd_m;
    logic [3:0] bcd_t;
    logic [3:0] bcd_u;
    logic [7:0] bcd_digit;
    always_comb begin
        if (vx_reg >= 8'd200)      bcd_h = 2'd2;
        else if (vx_reg >= 8'd100) bcd_h = 2'd1;
        else                       bcd_h = 2'd0;
        bcd_r = 7'(vx_reg - 8'(bcd_h) * 8'd100);
        bcd_m = 15'(bcd_r) * 15'd205;
        bcd_t = bcd_m[14:11];
        bcd_u = 4'(bcd_r - 7'(bcd_t) * 7'd10);
        case (step_reg)
            5'd0:    bcd_digit = {6'd0, bcd_h};
            5'd1:    bcd_digit = {4'd0, bcd_t};
            default: bcd_digit = {4'd0, bcd_u};
        endcase
    end

    // variable register read port
    logic [3:0] vrd_idx;
    logic [7:0] vrd;
    always_comb begin
        case (cmd.uop)
            UOP_READ_X: vrd_idx = op_x;
            UOP_READ_Y: vrd_idx = op_y;
            default:    vrd_idx = step_reg[3:0];
        endcase
    end
    assign vrd = var_reg[vrd_idx];

    // instruction class and loop termination
    cls_t cls;
    logic done;
    always_comb begin
        cls = CLS_NONE;
        if (op_hi == 4'hD) cls = CLS_DRAW;
        else if (op_hi == 4'hF && op_kk == 8'h33 && index_reg < 16'd4094) cls = CLS_BCD;
        else if (op_hi == 4'hF && op_kk == 8'h55) cls = CLS_STORE;
        else if (op_hi == 4'hF && op_kk == 8'h65) cls = CLS_LOAD;
        case (cmd.uop)
            UOP_DRAW_RD: done = (step_reg >= {1'b0, op_n}) || row_sum[5] ||
                                idx_sum[16:12] != 5'd0;
            UOP_BCD:     done = (step_reg == 5'd3);
            default:     done = (step_reg > {1'b0, op_x}) || idx_sum[16:12] != 5'd0;
        endcase
    end

    assign stat.req        = req_reg;
    assign stat.cls        = cls;
    assign stat.loop_done  = done;
    assign stat.clear_last = (clr_reg == 12'hFFF);

    // memory port selection
    always_comb begin
        ram_we    = 1'b0;
        ram_addr  = idx_sum[11:0];
        ram_wdata = vrd;
        case (cmd.uop)
            UOP_CLEAR: begin
                ram_we    = 1'b1;
                ram_addr  = clr_reg;
                ram_wdata = (clr_reg < 12'(FONT_BYTES)) ? font_byte(clr_reg[6:0]) : 8'd0;
            end
            UOP_DISPATCH: begin
                ram_we    = (req_reg == REQ_WRITE);
                ram_addr  = (req_reg == REQ_WRITE) ? addr_reg : pc_reg;
                ram_wdata = wdata_reg;
            end
            UOP_FETCH_HI: ram_addr = pc_reg + 12'd1;
            UOP_BCD: begin
                ram_we    = !done;
                ram_wdata = bcd_digit;
            end
            UOP_STORE: ram_we = !done;
            default: ram_we = 1'b0;
        endcase
    end

    // alu results
    logic [8:0]  add9;
    logic [11:0] pc2;
    logic [3:0]  low_key;
    logic [15:0] lfsr_step;
    assign add9      = {1'b0, vx_reg} + {1'b0, vy_reg};
    assign pc2       = pc_reg + 12'd2;
    assign lfsr_step = {lfsr_reg[0] ^ lfsr_reg[2] ^ lfsr_reg[3] ^ lfsr_reg[5], lfsr_reg[15:1]};
    always_comb begin
        low_key = 4'd0;
        for (int k = 15; k >= 0; k--) begin
            if (keys_reg[k]) low_key = 4'(k);
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (cmd.in_xfer) begin
            req_reg   <= s_tuser;
            addr_reg  <= s_tdata[11:0];
            wdata_reg <= s_tdata[19:12];
            keys_reg  <= s_tdata[35:20];
        end
        case (cmd.uop)
            UOP_FETCH_HI: op_reg[15:8] <= ram_rdata;
            UOP_FETCH_LO: op_reg[7:0]  <= ram_rdata;
            UOP_READ_X:   vx_reg <= vrd;
            UOP_READ_Y:   vy_reg <= vrd;
            default: ;
        endcase
        if (cmd.uop == UOP_EXEC && op_hi == 4'h2 && sp_reg < SP_W'(STACK_DEPTH)) begin
            stack_reg[sp_reg[SP_IDX_W-1:0]] <= pc2;
        end
        if (cmd.out_load) begin
            out_reg <= {7'd0,
                        (req_reg == REQ_ROW && addr_reg < 12'd32) ? fb_reg[addr_reg[4:0]] : 64'd0,
                        sound_reg != 8'd0, drew_reg, index_reg, pc_reg, status_reg};
        end
    end
    assign m_tdata = out_reg;

    // state updates
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < 16; i++) var_reg[i] <= 8'd0;
            for (int i = 0; i < 32; i++) fb_reg[i] <= 64'd0;
            index_reg    <= 16'd0;
            pc_reg       <= START_DEFAULT;
            sp_reg       <= '0;
            delay_reg    <= 8'd0;
            sound_reg    <= 8'd0;
            key_wait_reg <= 1'b0;
            lfsr_reg     <= SEED_DEFAULT;
            step_reg     <= '0;
            clr_reg      <= 12'd0;
            hit_reg      <= 1'b0;
            status_reg   <= STAT_OK;
            drew_reg     <= 1'b0;
        end else begin
            // configuration writes
            if (cfg_wr_en && cfg_index == CFG_START) pc_reg <= cfg_wdata[11:0];
            if (cfg_wr_en && cfg_index == CFG_SEED) begin
                lfsr_reg <= (cfg_wdata == 16'd0) ? SEED_DEFAULT : cfg_wdata;
            end
            if (cmd.in_xfer) begin
                status_reg <= STAT_OK;
                drew_reg   <= 1'b0;
            end
            case (cmd.uop)
                UOP_CLEAR: clr_reg <= clr_reg + 12'd1;
                UOP_DISPATCH: begin
                    if (req_reg == REQ_TICK) begin
                        if (delay_reg != 8'd0) delay_reg <= delay_reg - 8'd1;
                        if (sound_reg != 8'd0) sound_reg <= sound_reg - 8'd1;
                    end
                end
                UOP_EXEC: begin
                    step_reg <= '0;
                    hit_reg  <= 1'b0;
                    pc_reg   <= pc2;
                    case (op_hi)
                        4'h0: begin
                            if (op_reg == 16'h00E0) begin
                                for (int i = 0; i < 32; i++) fb_reg[i] <= 64'd0;
                                drew_reg <= 1'b1;
                            end else if (op_reg == 16'h00EE) begin
                                if (sp_reg == '0) begin
                                    status_reg <= STAT_UNDERFLOW;
                                end else begin
                                    sp_reg <= sp_reg - 1'b1;
                                    pc_reg <= stack_reg[SP_IDX_W'(sp_reg - 1'b1)];
                                end
                            end else begin
                                status_reg <= STAT_UNKNOWN;
                            end
                        end
                        4'h1: pc_reg <= op_nnn;
                        4'h2: begin
                            if (sp_reg >= SP_W'(STACK_DEPTH)) begin
                                status_reg <= STAT_OVERFLOW;
                            end else begin
                                sp_reg <= sp_reg + 1'b1;
                                pc_reg <= op_nnn;
                            end
                        end
                        4'h3: if (vx_reg == op_kk) pc_reg <= pc_reg + 12'd4;
                        4'h4: if (vx_reg != op_kk) pc_reg <= pc_reg + 12'd4;
                        4'h5: if (vx_reg == vy_reg) pc_reg <= pc_reg + 12'd4;
                        4'h6: var_reg[op_x] <= op_kk;
                        4'h7: var_reg[op_x] <= vx_reg + op_kk;
                        4'h8: begin
                            case (op_n)
                                4'h0: var_reg[op_x] <= vy_reg;
                                4'h1: var_reg[op_x] <= vx_reg | vy_reg;
                                4'h2: var_reg[op_x] <= vx_reg & vy_reg;
                                4'h3: var_reg[op_x] <= vx_reg ^ vy_reg;
                                4'h4: begin
                                    var_reg[op_x] <= add9[7:0];
                                    var_reg[15]   <= {7'd0, add9[8]};
                                end
                                4'h5: begin
                                    var_reg[op_x] <= vx_reg - vy_reg;
                                    var_reg[15]   <= {7'd0, vx_reg >= vy_reg};
                                end
                                4'h6: begin
                                    var_reg[op_x] <= {1'b0, vx_reg[7:1]};
                                    var_reg[15]   <= {7'd0, vx_reg[0]};
                                end
                                4'h7: begin
                                    var_reg[op_x] <= vy_reg - vx_reg;
                                    var_reg[15]   <= {7'd0, vy_reg >= vx_reg};
                                end
                                4'hE: begin
                                    var_reg[op_x] <= {vx_reg[6:0], 1'b0};
                                    var_reg[15]   <= {7'd0, vx_reg[7]};
                                end
                                default: status_reg <= STAT_UNKNOWN;
                            endcase
                        end
                        4'h9: if (vx_reg != vy_reg) pc_reg <= pc_reg + 12'd4;
                        4'hA: index_reg <= {4'd0, op_nnn};
                        4'hB: pc_reg <= op_nnn + {4'd0, var_reg[0]};
                        4'hC: begin
                            lfsr_reg      <= lfsr_step;
                            var_reg[op_x] <= lfsr_step[7:0] & op_kk;
                        end
                        4'hD: drew_reg <= 1'b1;
                        4'hE: begin
                            if (op_kk == 8'h9E) begin
                                if (keys_reg[vx_reg[3:0]]) pc_reg <= pc_reg + 12'd4;
                            end else if (op_kk == 8'hA1) begin
                                if (!keys_reg[vx_reg[3:0]]) pc_reg <= pc_reg + 12'd4;
                            end else begin
                                status_reg <= STAT_UNKNOWN;
                            end
                        end
                        default: begin
                            case (op_kk)
                                8'h07: var_reg[op_x] <= delay_reg;
                                8'h0A: begin
                                    if (!key_wait_reg) begin
                                        if (keys_reg != 16'd0) begin
                                            var_reg[op_x] <= {4'd0, low_key};
                                            key_wait_reg  <= 1'b1;
                                        end
                                        pc_reg     <= pc_reg;
                                        status_reg <= STAT_KEY_WAIT;
                                    end else if (keys_reg == 16'd0) begin
                                        key_wait_reg <= 1'b0;
                                    end else begin
                                        pc_reg     <= pc_reg;
                                        status_reg <= STAT_KEY_WAIT;
                                    end
                                end
                                8'h15: delay_reg <= vx_reg;
                                8'h18: sound_reg <= vx_reg;
                                8'h1E: index_reg <= index_reg + {8'd0, vx_reg};
                                8'h29: index_reg <= {6'd0, vx_reg, 2'd0} + {8'd0, vx_reg};
                                8'h33, 8'h55, 8'h65: ;
                                default: status_reg <= STAT_UNKNOWN;
                            endcase
                        end
                    endcase
                end
                UOP_DRAW_RD: if (done) var_reg[15] <= {7'd0, hit_reg};
                UOP_DRAW_WR: begin
                    if ((fb_reg[row_idx] & sprite_row) != 64'd0) hit_reg <= 1'b1;
                    fb_reg[row_idx] <= fb_reg[row_idx] ^ sprite_row;
                    step_reg        <= step_reg + 1'b1;
                end
                UOP_BCD, UOP_STORE: if (!done) step_reg <= step_reg + 1'b1;
                UOP_LOAD_WR: begin
                    var_reg[step_reg[3:0]] <= ram_rdata;
                    step_reg               <= step_reg + 1'b1;
                end
                default: ;
            endcase
        end
    end

endmodule

`default_nettype wire

// ===== rtl/chip8_instruction_core.sv =====
// ----------------------------------------------------------------------------
// chip8_instruction_core
// Interpreter core: executes one instruction, writes memory, ticks timers
// or reads a display row per request.
// ----------------------------------------------------------------------------
//  channel   ports                                  contents
//  request   s_tvalid s_tready s_tuser s_tdata[39:0]  req_type; address, write_data, keys
//  result    m_tvalid m_tready m_tdata[103:0]         status .. row_pixels
//  config    cfg_wr_en cfg_index cfg_wdata            start_address, random_seed
//
//  Memory write, frame tick and row read: dispatch, then response. An
//  instruction fetches, reads operands, executes, then loops: draw reads
//  and writes per row, Fx55 writes, Fx65 reads and writes per byte, each
//  with a closing step; Fx33 writes three digits, set by the single port.
//  After reset a clearing pass over all 4096 bytes loads the font and zeros
//  memory, taking no request. A stalled result holds the core in response.
// ----------------------------------------------------------------------------
`default_nettype none

module chip8_instruction_core (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    // req_type[1:0]
    input  wire logic [1:0]                    s_tuser,
    // address[11:0], write_data[19:12], keys[35:20]
    input  wire logic [c8_pkg::IN_W-1:0]       s_tdata,
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    // status[2:0], program_counter[14:3], index_value[30:15],
    // display_changed[31], sound_on[32], row_pixels[96:33]
    output logic      [c8_pkg::OUT_W-1:0]      m_tdata,
    input  wire logic                          cfg_wr_en,
    input  wire logic [c8_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [c8_pkg::CFG_W-1:0]      cfg_wdata
);
    import c8_pkg::*;

    cmd_t  cmd;
    stat_t stat;

    // sequencer
    c8_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // registers, memory and display
    c8_datapath u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .stat      (stat),
        .s_tuser   (s_tuser),
        .s_tdata   (s_tdata),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .m_tdata   (m_tdata)
    );

endmodule

`default_nettype wire
